FILE: sv/mrsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrsp_pkg;

    // Result kinds as carried on the kind port
    typedef enum logic [1:0] {
        KIND_MESSAGE     = 2'd0,
        KIND_SYSEX_BYTE  = 2'd1,
        KIND_SYSEX_START = 2'd2
    } kind_t;

    // Status codes with special handling
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_REALTIME    = 8'hF8;
    localparam logic [7:0] ST_SYSTEM      = 8'hF0;
    localparam logic [7:0] ST_CHANNEL     = 8'h80;

    // Parser state carried from item to item
    typedef struct packed {
        logic [7:0] running_status;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [1:0] bytes_left;
        logic       in_sysex;
    } parse_state_t;

    // One result, with its presence flag
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] msg_status;
        logic [6:0] msg_data1;
        logic [6:0] msg_data2;
        logic [6:0] sysex_byte;
    } parse_result_t;

    // Total bytes of a message, status included, from its status byte
    function automatic logic [1:0] msg_length(input logic [7:0] status);
        logic [1:0] len;
        begin
            len = 2'd1;
            if (status < ST_SYSTEM) begin
                case (status[7:4])
                    4'hC, 4'hD: len = 2'd2;
                    default:    len = 2'd3;
                endcase
            end
            else begin
                case (status)
                    8'hF2:        len = 2'd3;
                    8'hF1, 8'hF3: len = 2'd2;
                    default:      len = 2'd1;
                endcase
            end
            return len;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/mrsp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mrsp_step
    import mrsp_pkg::*;
(
    input  wire  parse_state_t  cur,
    input  wire  logic [7:0]    rx_byte,
    output parse_state_t        nxt,
    output parse_result_t       res
);

    logic [1:0] len;
    logic [1:0] pos;
    logic [1:0] left;

    always_comb
    begin
        nxt  = cur;
        res  = '0;
        len  = msg_length(cur.running_status);
        pos  = 2'd0;
        left = cur.bytes_left;

        if (rx_byte[7]) begin
            // Status byte
            if (rx_byte >= ST_REALTIME) begin
                // Real-time: emit at once, leave state alone
                res.valid      = 1'b1;
                res.kind       = KIND_MESSAGE;
                res.msg_status = rx_byte;
                res.msg_data1  = cur.first_data;
                res.msg_data2  = cur.second_data;
            end
            else begin
                nxt.running_status = rx_byte;
                if (rx_byte == ST_SYSEX_START) begin
                    nxt.in_sysex   = 1'b1;
                    nxt.bytes_left = 2'd0;
                    res.valid      = 1'b1;
                    res.kind       = KIND_SYSEX_START;
                end
                else begin
                    nxt.in_sysex = 1'b0;
                    if (rx_byte == ST_SYSEX_END) begin
                        nxt.bytes_left = 2'd0;
                    end
                    else begin
                        nxt.bytes_left = msg_length(rx_byte) - 2'd1;
                        if (msg_length(rx_byte) == 2'd1) begin
                            res.valid      = 1'b1;
                            res.kind       = KIND_MESSAGE;
                            res.msg_status = rx_byte;
                            res.msg_data1  = cur.first_data;
                            res.msg_data2  = cur.second_data;
                        end
                    end
                end
            end
        end
        else if (cur.in_sysex) begin
            // Pass sysex data through
            res.valid      = 1'b1;
            res.kind       = KIND_SYSEX_BYTE;
            res.sysex_byte = rx_byte[6:0];
        end
        else if (cur.bytes_left != 2'd0 ||
                 (cur.running_status >= ST_CHANNEL && cur.running_status < ST_SYSTEM)) begin
            // Data byte: start a running-status message or continue one
            if (cur.bytes_left == 2'd0) begin
                pos  = 2'd1;
                left = len - 2'd1;
            end
            else begin
                pos = (cur.bytes_left <= len) ? len - cur.bytes_left : 2'd0;
            end
            if (pos == 2'd1) begin
                nxt.first_data = rx_byte[6:0];
            end
            else if (pos == 2'd2) begin
                nxt.second_data = rx_byte[6:0];
            end
            nxt.bytes_left = left - 2'd1;
            if (nxt.bytes_left == 2'd0) begin
                res.valid      = 1'b1;
                res.kind       = KIND_MESSAGE;
                res.msg_status = cur.running_status;
                res.msg_data1  = nxt.first_data;
                res.msg_data2  = nxt.second_data;
            end
        end
        // Otherwise drop a data byte with no usable running status
    end

endmodule

`default_nettype wire

FILE: sv/mrsp_state_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module mrsp_state_reg
    import mrsp_pkg::*;
(
    input  wire  logic         clk,
    input  wire  logic         rst_n,
    input  wire  logic         advance,
    input  wire  parse_state_t state_next,
    output parse_state_t       state_q
);

    parse_state_t state_reg;

    // Update the parser state once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign state_q = state_reg;

endmodule

`default_nettype wire

FILE: sv/midi_running_status_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// MIDI byte-stream parser with running status.
// Input channel: rx_byte with in_valid / in_stall; one received byte per item.
// Output channel: kind, msg_status, msg_data1, msg_data2, sysex_byte with
// out_valid / out_stall; each input item gives zero or one result item.
// kind 0 is a complete channel, system common or real-time message, kind 1
// a data byte inside system exclusive, kind 2 the start of system exclusive.
// An accepted byte is held in the input register, decoded from there, and its
// result is loaded into the output register once that register is free.
// Throughput: one byte per cycle unless the receiver stalls, set by the single
// decode step between input and output register, which also updates the state.
// Reset clears the running status, data bytes, byte count and sysex flag,
// and empties both registers.
// When the receiver stalls, the result holds on the output ports; one more
// byte is taken into the input register, and in_stall is high while it waits.
module midi_running_status_parser
    import mrsp_pkg::*;
(
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       in_valid,
    output logic             in_stall,
    input  wire  logic [7:0] rx_byte,
    output logic             out_valid,
    input  wire  logic       out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       msg_status,
    output logic [6:0]       msg_data1,
    output logic [6:0]       msg_data2,
    output logic [6:0]       sysex_byte
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    parse_result_t out_reg;
    logic          out_free;
    logic          advance;
    parse_state_t  state_q;
    parse_state_t  state_next;
    parse_result_t res;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Input register: load a new item when empty or when the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            in_byte_reg <= rx_byte;
        end
    end

    mrsp_step u_step (
        .cur     (state_q),
        .rx_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (res)
    );

    mrsp_state_reg u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .state_next (state_next),
        .state_q    (state_q)
    );

    // Output register: refill when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign msg_status = out_reg.msg_status;
    assign msg_data1  = out_reg.msg_data1;
    assign msg_data2  = out_reg.msg_data2;
    assign sysex_byte = out_reg.sysex_byte;

endmodule

`default_nettype wire

FILE: sv/mrsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mrsp_checker
    import mrsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] msg_status,
    input  wire logic [6:0] msg_data1,
    input  wire logic [6:0] msg_data2,
    input  wire logic [6:0] sysex_byte
);

    // Kind is always one of the three result codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_MESSAGE || kind == KIND_SYSEX_BYTE ||
                       kind == KIND_SYSEX_START))
        else $error("mrsp: bad result kind");

    // A message carries a status byte, a sysex result carries none
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_MESSAGE) ? (msg_status[7] && sysex_byte == 7'd0)
                       : (msg_status == 8'd0 && msg_data1 == 7'd0 && msg_data2 == 7'd0)))
        else $error("mrsp: result fields do not match kind");

    // A start-of-sysex result has an empty sysex byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SYSEX_START) |-> sysex_byte == 7'd0)
        else $error("mrsp: sysex start with data");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(msg_status)
                                      && $stable(sysex_byte)))
        else $error("mrsp: stalled result changed");

    // Input is never stalled with no byte waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("mrsp: input stalled while output free");

endmodule

bind midi_running_status_parser mrsp_checker u_mrsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .msg_status (msg_status),
    .msg_data1  (msg_data1),
    .msg_data2  (msg_data2),
    .sysex_byte (sysex_byte)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mrsp_pkg::*;

    // One result as the parser should give it
    typedef struct packed {
        kind_t      kind;
        logic [7:0] msg_status;
        logic [6:0] msg_data1;
        logic [6:0] msg_data2;
        logic [6:0] sysex_byte;
    } midi_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] msg_status;
    logic [6:0] msg_data1;
    logic [6:0] msg_data2;
    logic [6:0] sysex_byte;

    // Shadow copy of the parser state
    logic [7:0] cur_status = 8'h00;
    logic [6:0] cur_data1 = 7'd0;
    logic [6:0] cur_data2 = 7'd0;
    logic [1:0] cur_left = 2'd0;
    logic       cur_sysex = 1'b0;

    midi_result_t pending_results[$];
    int           mismatch_count = 0;
    int           effective_items = 0;
    int           rx_wait = 0;
    bit           idle_en = 1'b0;

    midi_running_status_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .msg_status (msg_status),
        .msg_data1  (msg_data1),
        .msg_data2  (msg_data2),
        .sysex_byte (sysex_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes in a message, status included
    function automatic logic [1:0] status_length(input logic [7:0] s);
        logic [1:0] n;
        begin
            n = 2'd1;
            if (s < ST_SYSTEM)
                n = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 2'd2 : 2'd3;
            else if (s == 8'hF2)
                n = 2'd3;
            else if (s == 8'hF1 || s == 8'hF3)
                n = 2'd2;
            return n;
        end
    endfunction

    task automatic push_result(input kind_t k, input logic [7:0] st, input logic [6:0] a,
                               input logic [6:0] b, input logic [6:0] x);
        midi_result_t r;
        begin
            r.kind = k;
            r.msg_status = st;
            r.msg_data1 = a;
            r.msg_data2 = b;
            r.sysex_byte = x;
            pending_results.push_back(r);
        end
    endtask

    // Advance the shadow state by one byte and queue any result it gives
    task automatic predict_parse(input logic [7:0] b, output bit effective);
        logic [1:0] len;
        logic [1:0] pos;
        begin
            effective = 1'b1;
            if (b[7]) begin
                if (b >= ST_REALTIME) begin
                    push_result(KIND_MESSAGE, b, cur_data1, cur_data2, 7'd0);
                end
                else begin
                    cur_status = b;
                    if (b == ST_SYSEX_START) begin
                        cur_sysex = 1'b1;
                        cur_left = 2'd0;
                        push_result(KIND_SYSEX_START, 8'h00, 7'd0, 7'd0, 7'd0);
                    end
                    else begin
                        cur_sysex = 1'b0;
                        if (b == ST_SYSEX_END) begin
                            cur_left = 2'd0;
                        end
                        else begin
                            cur_left = status_length(b) - 2'd1;
                            if (cur_left == 2'd0)
                                push_result(KIND_MESSAGE, b, cur_data1, cur_data2, 7'd0);
                        end
                    end
                end
            end
            else if (cur_sysex) begin
                push_result(KIND_SYSEX_BYTE, 8'h00, 7'd0, 7'd0, b[6:0]);
            end
            else begin
                len = status_length(cur_status);
                pos = 2'd0;
                if (cur_left == 2'd0) begin
                    // Drop data with no channel status to run on
                    if (cur_status < ST_CHANNEL || cur_status >= ST_SYSTEM) begin
                        effective = 1'b0;
                    end
                    else begin
                        pos = 2'd1;
                        cur_left = len - 2'd1;
                    end
                end
                else begin
                    pos = (cur_left <= len) ? len - cur_left : 2'd0;
                end
                if (effective) begin
                    if (pos == 2'd1)
                        cur_data1 = b[6:0];
                    else if (pos == 2'd2)
                        cur_data2 = b[6:0];
                    cur_left = cur_left - 2'd1;
                    if (cur_left == 2'd0)
                        push_result(KIND_MESSAGE, cur_status, cur_data1, cur_data2, 7'd0);
                end
            end
        end
    endtask

    // Send one item, after a random gap when idle_en is set, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit eff;
        begin
            gap = idle_en ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            predict_parse(b, eff);
            if (eff)
                effective_items++;
            in_valid <= 1'b1;
            rx_byte <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    // Data byte, now and then preceded by a real-time byte
    task automatic send_data(input logic [6:0] d);
        begin
            if ($urandom_range(0, 19) == 0)
                send_byte(8'($urandom_range(8'hF8, 8'hFF)));
            send_byte({1'b0, d});
        end
    endtask

    task automatic report(input string what, input midi_result_t e);
        begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $write("%0t %s: exp kind %0d st %h d1 %h d2 %h sx %h, ",
                       $realtime, what, e.kind, e.msg_status, e.msg_data1,
                       e.msg_data2, e.sysex_byte);
                $display("got kind %0d st %h d1 %h d2 %h sx %h",
                         kind, msg_status, msg_data1, msg_data2, sysex_byte);
            end
        end
    endtask

    // Check each accepted result and draw the stall before the next one
    always @(posedge clk)
    begin : result_check
        midi_result_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    e = '0;
                    report("unexpected result", e);
                end
                else begin
                    e = pending_results.pop_front();
                    if (kind != e.kind || msg_status != e.msg_status
                        || msg_data1 != e.msg_data1 || msg_data2 != e.msg_data2
                        || sysex_byte != e.sysex_byte)
                        report("result mismatch", e);
                end
                rx_wait = idle_en ? $urandom_range(0, 16) : 0;
            end
            else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= (rx_wait > 0);
        end
    end

    // Channel voice messages with running status and a real-time byte inside
    task automatic test_channel_messages();
        begin
            send_byte(8'h7F);
            send_byte(8'h90);
            send_byte(8'h00);
            send_byte(8'h7F);
            send_byte(8'h3C);
            send_byte(8'hF8);
            send_byte(8'h00);
            send_byte(8'hC5);
            send_byte(8'h7F);
        end
    endtask

    // System common messages, a one-byte status and stray end of exclusive
    task automatic test_system_messages();
        begin
            send_byte(8'hF1);
            send_byte(8'h7F);
            send_byte(8'h00);
            send_byte(8'hF2);
            send_byte(8'h01);
            send_byte(8'h7F);
            send_byte(8'hF6);
            send_byte(8'hF7);
            send_byte(8'h10);
        end
    endtask

    // System exclusive with real-time, a restart and a status that ends it
    task automatic test_sysex();
        begin
            send_byte(8'hF0);
            send_byte(8'h00);
            send_byte(8'h7F);
            send_byte(8'hFE);
            send_byte(8'hF0);
            send_byte(8'hA0);
            send_byte(8'h01);
            send_byte(8'h02);
        end
    endtask

    // Mostly well-formed messages with random content, some noise
    task automatic test_random_stream(input int n_items, input bit idle);
        int start;
        int pick;
        int k;
        int i;
        logic [7:0] st;
        begin
            idle_en = idle;
            start = effective_items;
            while (effective_items - start < n_items) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    st = 8'($urandom_range(8'h80, 8'hEF));
                    send_byte(st);
                    for (i = 1; i < status_length(st); i++)
                        send_data(7'($urandom_range(0, 127)));
                end
                else if (pick < 50) begin
                    k = (cur_status < ST_SYSTEM) ? status_length(cur_status) - 1 : 2;
                    for (i = 0; i < k; i++)
                        send_data(7'($urandom_range(0, 127)));
                end
                else if (pick < 60) begin
                    st = 8'($urandom_range(8'hF1, 8'hF6));
                    send_byte(st);
                    for (i = 1; i < status_length(st); i++)
                        send_data(7'($urandom_range(0, 127)));
                end
                else if (pick < 75) begin
                    send_byte(ST_SYSEX_START);
                    k = $urandom_range(0, 6);
                    for (i = 0; i < k; i++)
                        send_data(7'($urandom_range(0, 127)));
                    if ($urandom_range(0, 3) != 0)
                        send_byte(ST_SYSEX_END);
                    else
                        send_byte(8'($urandom_range(8'h80, 8'hF6)));
                end
                else if (pick < 85) begin
                    send_byte(8'($urandom_range(8'hF8, 8'hFF)));
                end
                else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Run limit
    initial
    begin
        #5_000_000;
        $display("midi_running_status_parser: mismatch");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_channel_messages();
        idle_en = 1'b1;
        test_system_messages();
        test_sysex();
        test_random_stream(500, 1'b1);
        test_random_stream(200, 1'b0);
        test_random_stream(500, 1'b1);
        in_valid <= 1'b0;
        // Drain the outstanding results, then allow for the pipeline
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("midi_running_status_parser: match");
        else
            $display("midi_running_status_parser: mismatch");
        $finish;
    end

endmodule

FILE: midi_running_status_parser.f
sv/mrsp_pkg.sv
sv/mrsp_step.sv
sv/mrsp_state_reg.sv
sv/midi_running_status_parser.sv
sv/mrsp_checker.sv
tb/tb.sv
